/* design/sfcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, constants and the CRC-8 byte step for the sensor frame
// decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

	localparam logic [7:0]  CRC_POLY        = 8'h31;   // 0x131 without the top bit
	localparam logic [7:0]  CRC_INIT        = 8'hFF;
	localparam int unsigned TEMP_SPAN_CENTI = 17500;
	localparam int unsigned TEMP_OFFSET     = 4500;
	localparam int unsigned HUM_SPAN_CENTI  = 10000;
	localparam int unsigned RAW_FULL_SCALE  = 65535;

	typedef enum logic [2:0] {
		POS_T_HI,
		POS_T_LO,
		POS_T_CRC,
		POS_H_HI,
		POS_H_LO,
		POS_H_CRC
	} pos_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_CRC = 2'd1,
		STATUS_HUM_CRC  = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] raw_t;
		logic [15:0] raw_h;
		status_t     status;
	} frame_res_t;

	// One CRC-8 byte step, MSB first, no reflection.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* design/sfcd_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_frame
// Byte position tracker and CRC checker for the six-byte reply.
// ----------------------------------------------------------------------------
module sfcd_frame import sfcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic        frame_first,
	output logic        emit,
	output frame_res_t  res
);

	pos_t       state_q, state_d;
	logic [7:0] crc_q, crc_d;
	logic [15:0] temp_word_q, temp_word_d;
	logic [7:0] hum_hi_q, hum_hi_d;
	logic [7:0] hum_lo_q, hum_lo_d;
	logic       temp_good_q, temp_good_d;
	pos_t       pos;
	logic [7:0] crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= POS_T_HI;
			crc_q       <= CRC_INIT;
			temp_word_q <= '0;
			hum_hi_q    <= '0;
			hum_lo_q    <= '0;
			temp_good_q <= 1'b0;
		end else if (step) begin
			state_q     <= state_d;
			crc_q       <= crc_d;
			temp_word_q <= temp_word_d;
			hum_hi_q    <= hum_hi_d;
			hum_lo_q    <= hum_lo_d;
			temp_good_q <= temp_good_d;
		end
	end

	always_comb begin
		pos         = frame_first ? POS_T_HI : state_q;
		crc_next    = crc8_step(crc_q, rx_byte);
		state_d     = state_q;
		crc_d       = crc_q;
		temp_word_d = temp_word_q;
		hum_hi_d    = hum_hi_q;
		hum_lo_d    = hum_lo_q;
		temp_good_d = temp_good_q;
		emit        = 1'b0;
		res.raw_t   = temp_word_q;
		res.raw_h   = {hum_hi_q, hum_lo_q};
		if (!temp_good_q) begin
			res.status = STATUS_TEMP_CRC;
		end else if (crc_q != rx_byte) begin
			res.status = STATUS_HUM_CRC;
		end else begin
			res.status = STATUS_OK;
		end
		case (pos)
			POS_T_LO: begin
				crc_d       = crc_next;
				temp_word_d = {temp_word_q[15:8], rx_byte};
				state_d     = POS_T_CRC;
			end
			POS_T_CRC: begin
				temp_good_d = (crc_q == rx_byte);
				crc_d       = CRC_INIT;
				state_d     = POS_H_HI;
			end
			POS_H_HI: begin
				crc_d    = crc_next;
				hum_hi_d = rx_byte;
				state_d  = POS_H_LO;
			end
			POS_H_LO: begin
				crc_d    = crc_next;
				hum_lo_d = rx_byte;
				state_d  = POS_H_CRC;
			end
			POS_H_CRC: begin
				emit    = step;
				crc_d   = CRC_INIT;
				state_d = POS_T_HI;
			end
			default: begin
				// first byte, also any stray position
				crc_d       = crc8_step(CRC_INIT, rx_byte);
				temp_word_d = {rx_byte, 8'h00};
				state_d     = POS_T_LO;
			end
		endcase
	end

endmodule

/* design/sfcd_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_scale
// Converts raw words to hundredths of a degree and of a percent.
// ----------------------------------------------------------------------------
module sfcd_scale import sfcd_pkg::*; (
	input  logic [15:0]        raw_t,
	input  logic [15:0]        raw_h,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi
);

	logic [31:0] t_prod, h_prod;
	logic [15:0] t_q0, h_q0, t_q, h_q;
	logic [16:0] t_rem, h_rem;
	logic [15:0] t_off;

	// x / 65535: q0 = x >> 16 leaves remainder lo + q0, below twice the divisor
	always_comb begin
		t_prod = {16'd0, raw_t} * 32'(TEMP_SPAN_CENTI);
		h_prod = {16'd0, raw_h} * 32'(HUM_SPAN_CENTI);
		t_q0   = t_prod[31:16];
		h_q0   = h_prod[31:16];
		t_rem  = {1'b0, t_prod[15:0]} + {1'b0, t_q0};
		h_rem  = {1'b0, h_prod[15:0]} + {1'b0, h_q0};
		t_q    = t_q0 + 16'(t_rem >= 17'(RAW_FULL_SCALE));
		h_q    = h_q0 + 16'(h_rem >= 17'(RAW_FULL_SCALE));
		t_off  = t_q - 16'(TEMP_OFFSET);
		temperature_centi = signed'(t_off[14:0]);
		humidity_centi    = h_q[13:0];
	end

endmodule

/* design/sensor_frame_crc_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_top
// Checks and converts six-byte temperature/humidity sensor replies.
// ----------------------------------------------------------------------------
// Feed the reply bytes in bus order, one per transfer: temperature high,
// temperature low, temperature CRC-8, humidity high, humidity low, humidity
// CRC-8 (polynomial 0x31, init 0xFF). Raise frame_first on a byte to restart
// the frame there; a byte at the frame start is taken as the first byte even
// without the flag. The sixth byte yields one result transfer with both raw
// words, both converted values (truncated) and a status, where a bad
// temperature checksum wins over a bad humidity checksum; the other bytes
// yield nothing. The block takes one byte every cycle while no waiting result
// holds it back: each byte passes an input register, then the CRC step and
// scaling logic, and lands in the result register, from which the result of
// a frame is presented after its sixth byte has passed both registers.
// While a result waits, the input register still takes one more byte.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_top import sfcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               frame_first,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic [15:0]        raw_temperature,
	output logic [15:0]        raw_humidity,
	output logic [1:0]         frame_status
);

	// input stage
	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        frame_first_s1;

	// result register
	logic               out_valid_q;
	logic signed [14:0] temp_centi_q;
	logic [13:0]        hum_centi_q;
	logic [15:0]        raw_t_q;
	logic [15:0]        raw_h_q;
	logic [1:0]         status_q;

	logic               out_free;
	logic               s1_go;
	logic               emit;
	frame_res_t         res;
	logic signed [14:0] temp_centi;
	logic [13:0]        hum_centi;

	// advance the input stage whenever the result slot is free or drains now
	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && out_free;
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the byte until the stage advances
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1     <= rx_byte;
			frame_first_s1 <= frame_first;
		end
	end

	sfcd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_go),
		.rx_byte    (rx_byte_s1),
		.frame_first(frame_first_s1),
		.emit       (emit),
		.res        (res)
	);

	sfcd_scale u_scale (
		.raw_t            (res.raw_t),
		.raw_h            (res.raw_h),
		.temperature_centi(temp_centi),
		.humidity_centi   (hum_centi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// load the result only on the closing byte of a frame
	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			temp_centi_q <= temp_centi;
			hum_centi_q  <= hum_centi;
			raw_t_q      <= res.raw_t;
			raw_h_q      <= res.raw_h;
			status_q     <= res.status;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_centi_q;
	assign humidity_centi    = hum_centi_q;
	assign raw_temperature   = raw_t_q;
	assign raw_humidity      = raw_h_q;
	assign frame_status      = status_q;

	// back-pressure only comes from a held byte that cannot advance
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	// a new result only follows an advanced byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_go))
		else $error("result appeared without an advanced byte");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hum_centi_q <= 14'd10000))
		else $error("humidity out of range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (temp_centi_q >= -15'sd4500 && temp_centi_q <= 15'sd13000))
		else $error("temperature out of range");

endmodule
